// ===== rtl/core/mlpd_pkg.sv =====
// shared types and constants for the multichannel length-prefix deframer
// no dependencies; used by mlpd_step and the top level
package mlpd_pkg;

  localparam int CHANNELS  = 256;
  localparam int ADDR_W    = $clog2(CHANNELS);
  localparam int LEN_W     = 24;            // width of the shared length / remaining field
  localparam int LENGTH_BITS = 24;          // frame lengths must fit in this many bits
  localparam int CH_W      = 8;
  localparam int BYTE_W    = 8;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_OPEN_HS = 2'd1,
    CMD_OPEN_HD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_WAIT      = 3'd0,
    ST_HANDSHAKE = 3'd1,
    ST_HEADER    = 3'd2,
    ST_CONTENT   = 3'd3,
    ST_DOWN      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_EMPTY    = 3'd1,
    EV_HS_OK    = 3'd2,
    EV_HS_BAD   = 3'd3,
    EV_TOO_LONG = 3'd4,
    EV_OPEN_OK  = 3'd5,
    EV_OPEN_REJ = 3'd6
  } event_t;

  // per-channel state; len holds the partial header length in header state
  // and the bytes still due in content state
  typedef struct packed {
    logic [2:0]       status;
    logic [1:0]       hdr_cnt;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [2:0]        ev;
    logic [BYTE_W-1:0] payload;
    logic              last;
  } result_t;

endpackage

// ===== rtl/core/mlpd_step.sv =====
// per-item state update of the deframer: one channel entry in, updated entry and result out
// depends on mlpd_pkg
module mlpd_step import mlpd_pkg::*; (
  input  logic [1:0]        cmd,
  input  logic [CH_W-1:0]   channel,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              ch_ok,
  input  entry_t            cur,
  output entry_t            upd,
  output result_t           res
);

  logic [LEN_W-1:0] hdr_len;
  logic [LEN_W-1:0] rem_dec;
  logic             too_long;

  assign hdr_len  = {cur.len[LEN_W-BYTE_W-1:0], data_byte};
  assign rem_dec  = (cur.len == '0) ? '0 : cur.len - LEN_W'(1);
  assign too_long = (hdr_len >> LENGTH_BITS) != '0;

  always_comb begin
    upd = cur;
    res = '0;
    case (cmd)
      CMD_OPEN_HS, CMD_OPEN_HD: begin
        res.valid = 1'b1;
        if (!ch_ok || cur.status != ST_WAIT) begin
          res.ev = EV_OPEN_REJ;
        end else begin
          res.ev      = EV_OPEN_OK;
          upd.status  = (cmd == CMD_OPEN_HS) ? ST_HANDSHAKE : ST_HEADER;
          upd.hdr_cnt = '0;
          upd.len     = '0;
        end
      end
      CMD_DATA: begin
        if (ch_ok) begin
          case (cur.status)
            ST_HANDSHAKE: begin
              res.valid = 1'b1;
              if (data_byte != channel) begin
                res.ev     = EV_HS_BAD;
                upd.status = ST_DOWN;
              end else begin
                res.ev      = EV_HS_OK;
                upd.status  = ST_HEADER;
                upd.hdr_cnt = '0;
                upd.len     = '0;
              end
            end
            ST_HEADER: begin
              if (cur.hdr_cnt == 2'd0) begin
                if (data_byte != '0) begin
                  res.valid  = 1'b1;
                  res.ev     = EV_TOO_LONG;
                  upd.status = ST_DOWN;
                end else begin
                  upd.len     = '0;
                  upd.hdr_cnt = 2'd1;
                end
              end else if (cur.hdr_cnt != 2'd3) begin
                upd.len     = hdr_len;
                upd.hdr_cnt = cur.hdr_cnt + 2'd1;
              end else begin
                upd.hdr_cnt = '0;
                upd.len     = '0;
                if (too_long) begin
                  res.valid  = 1'b1;
                  res.ev     = EV_TOO_LONG;
                  upd.status = ST_DOWN;
                end else if (hdr_len == '0) begin
                  res.valid = 1'b1;
                  res.ev    = EV_EMPTY;
                end else begin
                  upd.len    = hdr_len;
                  upd.status = ST_CONTENT;
                end
              end
            end
            ST_CONTENT: begin
              res.valid   = 1'b1;
              res.ev      = EV_PAYLOAD;
              res.payload = data_byte;
              res.last    = (rem_dec == '0);
              upd.len     = rem_dec;
              if (rem_dec == '0) begin
                upd.status  = ST_HEADER;
                upd.hdr_cnt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/multichannel_length_prefix_deframer.sv =====
// top level of the multichannel length-prefix deframer: channel state memory,
// read-modify-write pipeline with forwarding, output register; uses mlpd_pkg and mlpd_step
//
//  port group | role   | tdata (low bit up)                    | side bits
//  -----------+--------+---------------------------------------+----------------------
//  s_*        | input  | channel[7:0], data_byte[15:8]         | tuser = cmd
//  m_*        | output | out_channel[7:0], payload_byte[15:8]  | tuser = event_res,
//             |        |                                       | tlast = frame_last
//
// one transaction per cycle sustained unless m_tready stalls the output;
// the channel memory read is registered and sets the two-stage pipeline;
// back-to-back transactions on the same channel take the updated entry from a bypass
// rst clears the per-entry valid bits at once, so an entry never written reads as reset;
// no clearing pass is needed
// a stall on m_tready holds the pipeline stage and drops s_tready until the output drains
module multichannel_length_prefix_deframer import mlpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel [7:0], data_byte [15:8]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_channel [7:0], payload_byte [15:8]
  output logic [2:0]  m_tuser,   // event_res [2:0]
  output logic        m_tlast    // frame_last
);

  // channel state memory and its valid bits
  entry_t               mem [CHANNELS];
  logic [CHANNELS-1:0]  vld;

  // pipeline stage registers
  logic                 s1_valid;
  logic [1:0]           s1_cmd;
  logic [CH_W-1:0]      s1_ch;
  logic [BYTE_W-1:0]    s1_byte;
  logic                 s1_ok;
  entry_t               rd_entry;
  logic                 rd_vld;
  entry_t               byp;
  logic                 fwd;

  logic [CH_W-1:0]      in_ch;
  logic [ADDR_W-1:0]    in_addr;
  logic [ADDR_W-1:0]    s1_addr;
  logic                 in_ok;
  logic                 accept;
  logic                 out_free;
  logic                 s1_fire;
  entry_t               cur;
  entry_t               upd;
  result_t              res;

  assign in_ch    = s_tdata[7:0];
  assign in_addr  = ADDR_W'(in_ch);
  assign s1_addr  = ADDR_W'(s1_ch);
  // channel zero and anything past the table are not valid links
  assign in_ok    = (in_ch != '0) && (32'(in_ch) < CHANNELS);

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && out_free;
  assign s_tready = !s1_valid || s1_fire;
  assign accept   = s_tvalid && s_tready;

  // current entry: bypass when the previous transaction wrote the same channel
  always_comb begin
    if (fwd) begin
      cur = byp;
    end else if (rd_vld) begin
      cur = rd_entry;
    end else begin
      cur = '0;
    end
  end

  mlpd_step u_step (
    .cmd       (s1_cmd),
    .channel   (s1_ch),
    .data_byte (s1_byte),
    .ch_ok     (s1_ok),
    .cur       (cur),
    .upd       (upd),
    .res       (res)
  );

  // memory read on accept, write-back when the stage retires on a valid channel
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry <= mem[in_addr];
    end
    if (s1_fire && s1_ok) begin
      mem[s1_addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_fire && s1_ok) begin
        vld[s1_addr] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        rd_vld   <= vld[in_addr];
        fwd      <= s1_fire && s1_ok && (s1_ch == in_ch);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        m_tvalid <= res.valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= s_tuser;
      s1_ch   <= in_ch;
      s1_byte <= s_tdata[15:8];
      s1_ok   <= in_ok;
      byp     <= upd;
    end
    if (s1_fire) begin
      m_tdata <= {res.payload, s1_ch};
      m_tuser <= res.ev;
      m_tlast <= res.last;
    end
  end

endmodule
